// ----- rtl/assert_macros.svh -----
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never hold at a rising clk edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

// ----- rtl/ddsf_pkg.sv -----
// types, constants and helpers of the dirty span flush encoder
package ddsf_pkg;

	// panel geometry
	localparam int PAGE_COUNT   = 8;
	localparam int COLUMN_COUNT = 128;
	localparam int STORE_DEPTH  = PAGE_COUNT * COLUMN_COUNT;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int PAGE_W       = $clog2(PAGE_COUNT + 1);
	localparam int COL_W        = $clog2(COLUMN_COUNT);

	// field widths
	localparam int OPCODE_W   = 2;
	localparam int PAGE_IDX_W = 3;
	localparam int COL_IDX_W  = 7;
	localparam int BYTE_W     = 8;
	localparam int COUNT_W    = 11;
	localparam int OFFSET_W   = 4;

	// stream widths
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 2;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_FLUSH   = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_REQUEST = 2'd2;

	// bus bytes
	localparam logic [BYTE_W-1:0] CTRL_CMD     = 8'h00;
	localparam logic [BYTE_W-1:0] CTRL_DATA    = 8'h40;
	localparam logic [BYTE_W-1:0] CMD_PAGE     = 8'hB0;
	localparam logic [BYTE_W-1:0] CMD_COL_HIGH = 8'h10;

	localparam logic [COUNT_W-1:0]  COUNT_MAX    = 11'h7FF;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd2;

	// one input beat
	typedef struct packed {
		logic [BYTE_W-1:0]     pixel_byte;
		logic [COL_IDX_W-1:0]  column_index;
		logic [PAGE_IDX_W-1:0] page_index;
		logic [OPCODE_W-1:0]   opcode;
	} in_beat_t;

	// one result beat
	typedef struct packed {
		logic [COUNT_W-1:0] span_bytes_total;
		logic               flush_done;
		logic               stop_flag;
		logic               restart_flag;
		logic [BYTE_W-1:0]  bus_byte;
	} word_t;

	// outcome of one page sweep
	typedef struct packed {
		logic             done;
		logic             found;
		logic [COL_W-1:0] low;
		logic [COL_W-1:0] high;
	} scan_res_t;

	// linear store address of a page and column
	function automatic logic [ADDR_W-1:0] store_addr(input logic [PAGE_W-1:0] page,
		input logic [COL_W-1:0] col);
		return ADDR_W'(int'(page) * COLUMN_COUNT + int'(col));
	endfunction

endpackage

// ----- rtl/display_dirty_span_flush_encoder.sv -----
// top level of the dirty span flush encoder
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser opcode, tdata page, column, pixel
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata bus byte, total; tuser flags; tlast stop
// cfg       in   cfg_we                         cfg_wdata column offset
//
// a pixel write leaves the sequencer in ST_IDLE and a flush start moves it to ST_SCAN;
// a command word request passes ST_WORD, a span byte request ST_WORD then ST_FETCH,
// since the frame store read data is registered. a flush start and the last byte of
// a page other than the last each launch a page sweep, one store column read per cycle.
// after reset both stores are cleared in a pass over all STORE_DEPTH addresses
// during which no beat is accepted; cfg writes are taken at any time.
// a result beat waiting on m_axis does not block pixel writes or flush starts.
module display_dirty_span_flush_encoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// page_index [2:0], column_index [9:3], pixel_byte [17:10]
	input  logic [ddsf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// opcode [1:0]
	input  logic [ddsf_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// bus_byte [7:0], span_bytes_total [18:8]
	output logic [ddsf_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// restart_flag [0], flush_done [1]
	output logic [ddsf_pkg::M_TUSER_W-1:0]  m_axis_tuser,
	output logic                            m_axis_tlast,
	input  logic                            cfg_we,
	input  logic [ddsf_pkg::OFFSET_W-1:0]   cfg_wdata
);

	logic [ddsf_pkg::OFFSET_W-1:0] column_offset_q;
	logic                          m_valid_q;
	ddsf_pkg::word_t               m_word_q;

	ddsf_pkg::in_beat_t            in_beat;
	logic                          out_free;
	logic                          out_load;
	ddsf_pkg::word_t               out_word;

	logic                          scan_start;
	logic                          scan_busy;
	logic                          scan_rd_en;
	logic [ddsf_pkg::COL_W-1:0]    scan_col;
	ddsf_pkg::scan_res_t           scan_res;

	logic                          frame_we;
	logic [ddsf_pkg::ADDR_W-1:0]   frame_waddr;
	logic [ddsf_pkg::BYTE_W-1:0]   frame_wdata;
	logic                          frame_re;
	logic [ddsf_pkg::ADDR_W-1:0]   store_raddr;
	logic [ddsf_pkg::BYTE_W-1:0]   frame_rdata;
	logic                          shadow_we;
	logic [ddsf_pkg::ADDR_W-1:0]   shadow_waddr;
	logic [ddsf_pkg::BYTE_W-1:0]   shadow_wdata;
	logic                          shadow_re;
	logic [ddsf_pkg::BYTE_W-1:0]   shadow_rdata;

	// input beat unpacking
	always_comb begin
		in_beat.opcode       = s_axis_tuser[1:0];
		in_beat.page_index   = s_axis_tdata[2:0];
		in_beat.column_index = s_axis_tdata[9:3];
		in_beat.pixel_byte   = s_axis_tdata[17:10];
	end

	// column offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_offset_q <= ddsf_pkg::OFFSET_RESET;
		end else if (cfg_we) begin
			column_offset_q <= cfg_wdata;
		end
	end

	// output register
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_word_q <= out_word;
		end
	end

	// output beat packing
	always_comb begin
		m_axis_tvalid = m_valid_q;
		m_axis_tdata  = ddsf_pkg::M_TDATA_W'({m_word_q.span_bytes_total, m_word_q.bus_byte});
		m_axis_tuser  = {m_word_q.flush_done, m_word_q.restart_flag};
		m_axis_tlast  = m_word_q.stop_flag;
	end

	// stores
	ddsf_ram #(
		.WIDTH (ddsf_pkg::BYTE_W),
		.DEPTH (ddsf_pkg::STORE_DEPTH)
	) u_frame_ram (
		.clk   (clk),
		.we    (frame_we),
		.waddr (frame_waddr),
		.wdata (frame_wdata),
		.re    (frame_re),
		.raddr (store_raddr),
		.rdata (frame_rdata)
	);

	ddsf_ram #(
		.WIDTH (ddsf_pkg::BYTE_W),
		.DEPTH (ddsf_pkg::STORE_DEPTH)
	) u_shadow_ram (
		.clk   (clk),
		.we    (shadow_we),
		.waddr (shadow_waddr),
		.wdata (shadow_wdata),
		.re    (shadow_re),
		.raddr (store_raddr),
		.rdata (shadow_rdata)
	);

	// page sweep
	ddsf_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (scan_start),
		.busy         (scan_busy),
		.rd_en        (scan_rd_en),
		.rd_col       (scan_col),
		.frame_rdata  (frame_rdata),
		.shadow_rdata (shadow_rdata),
		.res          (scan_res)
	);

	// sequencer
	ddsf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_beat       (in_beat),
		.out_free      (out_free),
		.out_load      (out_load),
		.out_word      (out_word),
		.column_offset (column_offset_q),
		.scan_start    (scan_start),
		.scan_busy     (scan_busy),
		.scan_col      (scan_col),
		.scan_res      (scan_res),
		.frame_we      (frame_we),
		.frame_waddr   (frame_waddr),
		.frame_wdata   (frame_wdata),
		.frame_re      (frame_re),
		.store_raddr   (store_raddr),
		.frame_rdata   (frame_rdata),
		.shadow_we     (shadow_we),
		.shadow_waddr  (shadow_waddr),
		.shadow_wdata  (shadow_wdata),
		.shadow_re     (shadow_re)
	);

	// checks
	`include "assert_macros.svh"

	`ASSERT_NEVER(a_load_into_busy_slot, out_load && m_valid_q && !m_axis_tready, "result loaded over a waiting beat")
	`ASSERT_CLK(a_done_beat_clean, m_valid_q && m_word_q.flush_done |-> !m_word_q.stop_flag && !m_word_q.restart_flag && (m_word_q.bus_byte == ddsf_pkg::CTRL_CMD), "done beat carries word fields")
	`ASSERT_CLK(a_restart_is_control, m_valid_q && m_word_q.restart_flag |-> (m_word_q.bus_byte == ddsf_pkg::CTRL_CMD) || (m_word_q.bus_byte == ddsf_pkg::CTRL_DATA), "restart on a non control byte")
	`ASSERT_NEVER(a_scan_read_clash, scan_rd_en && shadow_we, "shadow written during a page sweep")

endmodule

// ----- rtl/ddsf_ram.sv -----
// simple dual port ram with registered read data
module ddsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/ddsf_scan.sv -----
// page sweep: finds lowest and highest column where frame and shadow differ
module ddsf_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          rd_en,
	output logic [ddsf_pkg::COL_W-1:0]    rd_col,
	input  logic [ddsf_pkg::BYTE_W-1:0]   frame_rdata,
	input  logic [ddsf_pkg::BYTE_W-1:0]   shadow_rdata,
	output ddsf_pkg::scan_res_t           res
);

	localparam logic [ddsf_pkg::COL_W-1:0] LAST_COL = ddsf_pkg::COL_W'(ddsf_pkg::COLUMN_COUNT - 1);

	logic                       active_q;
	logic [ddsf_pkg::COL_W-1:0] col_q;
	logic                       cmp_valid_s1;
	logic [ddsf_pkg::COL_W-1:0] cmp_col_s1;
	logic                       found_q;
	logic [ddsf_pkg::COL_W-1:0] low_q;
	logic [ddsf_pkg::COL_W-1:0] high_q;
	logic                       diff;

	// read issue and compare result
	always_comb begin
		rd_en     = active_q;
		rd_col    = col_q;
		busy      = active_q | cmp_valid_s1;
		diff      = frame_rdata != shadow_rdata;
		res.done  = cmp_valid_s1 && (cmp_col_s1 == LAST_COL);
		res.found = found_q | diff;
		res.low   = found_q ? low_q : cmp_col_s1;
		res.high  = diff ? cmp_col_s1 : high_q;
	end

	// column counter and compare stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			col_q        <= '0;
			cmp_valid_s1 <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			cmp_valid_s1 <= active_q;
			if (start) begin
				active_q <= 1'b1;
				col_q    <= '0;
				found_q  <= 1'b0;
			end else begin
				if (active_q) begin
					col_q <= col_q + 1'b1;
					if (col_q == LAST_COL) begin
						active_q <= 1'b0;
					end
				end
				if (cmp_valid_s1 && diff) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// span bounds
	always_ff @(posedge clk) begin
		cmp_col_s1 <= col_q;
		if (cmp_valid_s1 && diff) begin
			if (!found_q) begin
				low_q <= cmp_col_s1;
			end
			high_q <= cmp_col_s1;
		end
	end

endmodule

// ----- rtl/ddsf_ctrl.sv -----
// flush sequencer: store accesses, word generation and shadow update
module ddsf_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ddsf_pkg::in_beat_t             in_beat,
	input  logic                           out_free,
	output logic                           out_load,
	output ddsf_pkg::word_t                out_word,
	input  logic [ddsf_pkg::OFFSET_W-1:0]  column_offset,
	output logic                           scan_start,
	input  logic                           scan_busy,
	input  logic [ddsf_pkg::COL_W-1:0]     scan_col,
	input  ddsf_pkg::scan_res_t            scan_res,
	output logic                           frame_we,
	output logic [ddsf_pkg::ADDR_W-1:0]    frame_waddr,
	output logic [ddsf_pkg::BYTE_W-1:0]    frame_wdata,
	output logic                           frame_re,
	output logic [ddsf_pkg::ADDR_W-1:0]    store_raddr,
	input  logic [ddsf_pkg::BYTE_W-1:0]    frame_rdata,
	output logic                           shadow_we,
	output logic [ddsf_pkg::ADDR_W-1:0]    shadow_waddr,
	output logic [ddsf_pkg::BYTE_W-1:0]    shadow_wdata,
	output logic                           shadow_re
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WORD,
		ST_FETCH,
		ST_SCAN
	} state_t;

	typedef enum logic [2:0] {
		PH_PAGE_CTRL,
		PH_PAGE_CMD,
		PH_LOW_CTRL,
		PH_LOW_CMD,
		PH_HIGH_CTRL,
		PH_HIGH_CMD,
		PH_DATA_CTRL,
		PH_SPAN
	} phase_t;

	localparam logic [ddsf_pkg::PAGE_W-1:0] PAGE_END  = ddsf_pkg::PAGE_W'(ddsf_pkg::PAGE_COUNT);
	localparam logic [ddsf_pkg::ADDR_W-1:0] ADDR_LAST = ddsf_pkg::ADDR_W'(ddsf_pkg::STORE_DEPTH - 1);

	state_t                          state_q;
	phase_t                          phase_q;
	logic [ddsf_pkg::ADDR_W-1:0]     clear_addr_q;
	logic [ddsf_pkg::PAGE_W-1:0]     page_q;
	logic [ddsf_pkg::COL_W-1:0]      span_low_q;
	logic [ddsf_pkg::COL_W-1:0]      span_high_q;
	logic [ddsf_pkg::COL_W-1:0]      emit_col_q;
	logic                            flushing_q;
	logic [ddsf_pkg::COUNT_W-1:0]    sent_q;

	logic                            accept;
	logic                            page_live;
	logic                            span_phase;
	logic                            span_last;
	logic                            write_ok;
	logic [ddsf_pkg::PAGE_W-1:0]     next_page;
	logic [ddsf_pkg::BYTE_W-1:0]     col_sum;
	logic [ddsf_pkg::ADDR_W-1:0]     write_addr;

	// handshake and flush status
	always_comb begin
		in_ready   = state_q == ST_IDLE;
		accept     = in_valid && in_ready;
		page_live  = flushing_q && (page_q < PAGE_END);
		span_phase = page_live && (phase_q == PH_SPAN);
		span_last  = emit_col_q >= span_high_q;
		next_page  = page_q + 1'b1;
		col_sum    = ddsf_pkg::BYTE_W'(column_offset) + ddsf_pkg::BYTE_W'(span_low_q);
		write_ok   = !flushing_q && (int'(in_beat.page_index) < ddsf_pkg::PAGE_COUNT)
			&& (int'(in_beat.column_index) < ddsf_pkg::COLUMN_COUNT);
		write_addr = ddsf_pkg::store_addr(ddsf_pkg::PAGE_W'(in_beat.page_index),
			in_beat.column_index[ddsf_pkg::COL_W-1:0]);
	end

	// result word for the current phase
	always_comb begin
		out_word = '0;
		if (!page_live) begin
			out_word.flush_done       = 1'b1;
			out_word.span_bytes_total = sent_q;
		end else begin
			case (phase_q) inside
				PH_PAGE_CTRL, PH_LOW_CTRL, PH_HIGH_CTRL: begin
					out_word.bus_byte     = ddsf_pkg::CTRL_CMD;
					out_word.restart_flag = 1'b1;
				end
				PH_PAGE_CMD: begin
					out_word.bus_byte  = ddsf_pkg::CMD_PAGE | ddsf_pkg::BYTE_W'(page_q);
					out_word.stop_flag = 1'b1;
				end
				PH_LOW_CMD: begin
					out_word.bus_byte  = ddsf_pkg::BYTE_W'(col_sum[3:0]);
					out_word.stop_flag = 1'b1;
				end
				PH_HIGH_CMD: begin
					out_word.bus_byte  = ddsf_pkg::CMD_COL_HIGH | ddsf_pkg::BYTE_W'(col_sum[7:4]);
					out_word.stop_flag = 1'b1;
				end
				PH_DATA_CTRL: begin
					out_word.bus_byte     = ddsf_pkg::CTRL_DATA;
					out_word.restart_flag = 1'b1;
				end
				default: begin
					out_word.bus_byte  = frame_rdata;
					out_word.stop_flag = span_last;
				end
			endcase
		end
		out_load = out_free && ((state_q == ST_FETCH) || ((state_q == ST_WORD) && !span_phase));
	end

	// store port drivers
	always_comb begin
		frame_we     = (state_q == ST_CLEAR)
			|| (accept && (in_beat.opcode == ddsf_pkg::OP_WRITE) && write_ok);
		frame_waddr  = (state_q == ST_CLEAR) ? clear_addr_q : write_addr;
		frame_wdata  = (state_q == ST_CLEAR) ? '0 : in_beat.pixel_byte;
		scan_start   = (state_q == ST_SCAN) && !scan_busy;
		shadow_re    = (state_q == ST_SCAN) && !scan_start;
		frame_re     = shadow_re || ((state_q == ST_WORD) && span_phase);
		store_raddr  = ddsf_pkg::store_addr(page_q, (state_q == ST_SCAN) ? scan_col : emit_col_q);
		shadow_we    = (state_q == ST_CLEAR) || ((state_q == ST_FETCH) && out_free);
		shadow_waddr = (state_q == ST_CLEAR) ? clear_addr_q
			: ddsf_pkg::store_addr(page_q, emit_col_q);
		shadow_wdata = (state_q == ST_CLEAR) ? '0 : frame_rdata;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			phase_q      <= PH_PAGE_CTRL;
			clear_addr_q <= '0;
			page_q       <= '0;
			span_low_q   <= '0;
			span_high_q  <= '0;
			emit_col_q   <= '0;
			flushing_q   <= 1'b0;
			sent_q       <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clear_addr_q <= clear_addr_q + 1'b1;
					if (clear_addr_q == ADDR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (in_beat.opcode)
							ddsf_pkg::OP_FLUSH: begin
								if (!flushing_q) begin
									flushing_q <= 1'b1;
									sent_q     <= '0;
									page_q     <= '0;
									state_q    <= ST_SCAN;
								end
							end
							ddsf_pkg::OP_REQUEST: begin
								state_q <= ST_WORD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WORD: begin
					if (span_phase) begin
						state_q <= ST_FETCH;
					end else if (out_free) begin
						if (!page_live) begin
							flushing_q <= 1'b0;
						end else begin
							phase_q <= phase_t'(phase_q + 1'b1);
							if (phase_q == PH_DATA_CTRL) begin
								emit_col_q <= span_low_q;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				ST_FETCH: begin
					if (out_free) begin
						if (sent_q != ddsf_pkg::COUNT_MAX) begin
							sent_q <= sent_q + 1'b1;
						end
						if (span_last) begin
							page_q  <= next_page;
							state_q <= (next_page == PAGE_END) ? ST_IDLE : ST_SCAN;
						end else begin
							emit_col_q <= emit_col_q + 1'b1;
							state_q    <= ST_IDLE;
						end
					end
				end
				ST_SCAN: begin
					if (scan_res.done) begin
						if (scan_res.found) begin
							span_low_q  <= scan_res.low;
							span_high_q <= scan_res.high;
							emit_col_q  <= scan_res.low;
							phase_q     <= PH_PAGE_CTRL;
							state_q     <= ST_IDLE;
						end else begin
							page_q <= next_page;
							if (next_page == PAGE_END) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
